// ----- rtl/core/utf8d_pkg.sv -----
// Package: shared types, byte-pattern constants and helpers for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  // Widths of the request and result fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned BCNT_W  = 3;
  localparam int unsigned PCNT_W  = 2;
  localparam int unsigned PEND_N  = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  // Results one request can cause, and depth of the result queue: one result
  // still waiting plus a full burst.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned QUEUE_DEPTH = 5;
  localparam int unsigned QCNT_W      = 3;

  // Lead and continuation byte patterns.
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] PAYLOAD6   = 8'h3F;
  localparam logic [7:0] PAYLOAD5   = 8'h1F;
  localparam logic [7:0] PAYLOAD4   = 8'h0F;
  localparam logic [7:0] PAYLOAD3   = 8'h07;

  // Sequence lengths as held in the expected-length register.
  localparam logic [BCNT_W-1:0] LEN_BAD = 3'd0;
  localparam logic [BCNT_W-1:0] LEN_1   = 3'd1;
  localparam logic [BCNT_W-1:0] LEN_2   = 3'd2;
  localparam logic [BCNT_W-1:0] LEN_3   = 3'd3;
  localparam logic [BCNT_W-1:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic              is_valid;
    logic [BCNT_W-1:0] byte_count;
    logic              last_of_run;
  } result_t;

  // Sequence length announced by a lead byte; LEN_BAD for a continuation
  // byte or one of 0xF8 to 0xFF.
  function automatic logic [BCNT_W-1:0] seq_length(input logic [BYTE_W-1:0] b);
    logic [BCNT_W-1:0] len;
    if ((b & ASCII_MASK) == 8'h00) begin
      len = LEN_1;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      len = LEN_2;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      len = LEN_3;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      len = LEN_4;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & CONT_MASK) == CONT_PAT;
  endfunction

endpackage

// ----- rtl/core/utf8_stream_decoder_core.sv -----
// Top level: UTF-8 byte stream decoder with a small result queue.
// A result joins the five-entry result queue as its byte is accepted, behind any still queued.
// Throughput: one byte per cycle while in_tready is high; a byte that only holds a lead or
// continuation gives no result. A broken sequence can cause a burst of up to four results,
// drained one per cycle while out_tready is high; in_tready is low while more than one is queued.
// Reset (rst_n, synchronous, active low) empties the queue and drops any held sequence.
`timescale 1ns / 1ps

module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // Byte requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_text
  // Decoded results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] byte_count
  output logic        out_tuser,  // is_valid
  output logic        out_tlast   // last_of_run
);

  localparam int unsigned QD = utf8d_pkg::QUEUE_DEPTH;
  localparam int unsigned MR = utf8d_pkg::MAX_RESULTS;

  // Held sequence state. The held bytes carry no reset: only entries below
  // the held count are ever read.
  logic [7:0] pend_r   [utf8d_pkg::PEND_N];
  logic [7:0] pend_nxt [utf8d_pkg::PEND_N];
  logic [utf8d_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [utf8d_pkg::BCNT_W-1:0] exp_len_r, exp_len_nxt;

  // Result queue: entry 0 is the head shown on the out_ ports.
  utf8d_pkg::result_t q_r   [QD];
  utf8d_pkg::result_t q_nxt [QD];
  logic [utf8d_pkg::QCNT_W-1:0] qcnt_r, qcnt_nxt;

  logic push, pop;
  logic [7:0] b;
  logic       eot;
  logic       cont;
  logic       complete;
  logic [utf8d_pkg::BCNT_W-1:0] len;
  logic [utf8d_pkg::PCNT_W-1:0] n_flush;
  logic       tail_en, tail_valid;
  logic [utf8d_pkg::CP_W-1:0]   tail_cp, decoded_cp;
  logic [utf8d_pkg::BCNT_W-1:0] tail_cnt;
  logic [utf8d_pkg::QCNT_W-1:0] new_n;
  logic [utf8d_pkg::QCNT_W-1:0] wr_base;
  logic [utf8d_pkg::QCNT_W-1:0] rel;
  utf8d_pkg::result_t new_items [MR];

  assign b   = in_tdata;
  assign eot = in_tlast;

  // Room for a full burst as long as at most one result is still waiting.
  assign in_tready  = (qcnt_r <= 3'd1);
  assign push       = in_tvalid & in_tready;
  assign out_tvalid = (qcnt_r != 3'd0);
  assign pop        = out_tvalid & out_tready;

  assign out_tdata = {q_r[0].byte_count, q_r[0].code_point};
  assign out_tuser = q_r[0].is_valid;
  assign out_tlast = q_r[0].last_of_run;

  assign cont     = utf8d_pkg::is_cont(b);
  assign len      = utf8d_pkg::seq_length(b);
  assign complete = ({1'b0, pcnt_r} + 3'd1) == exp_len_r;

  // Code point assembled from the held bytes and the completing byte.
  always_comb begin
    case (exp_len_r)
      utf8d_pkg::LEN_2: begin
        decoded_cp = {10'd0, pend_r[0][4:0], b[5:0]};
      end
      utf8d_pkg::LEN_3: begin
        decoded_cp = {5'd0, pend_r[0][3:0], pend_r[1][5:0], b[5:0]};
      end
      utf8d_pkg::LEN_4: begin
        decoded_cp = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], b[5:0]};
      end
      default: begin
        decoded_cp = '0;
      end
    endcase
  end

  // Decode of one byte: a run of flushed held bytes followed by at most one
  // tail result, plus the next held-sequence state.
  always_comb begin
    pend_nxt    = pend_r;
    pcnt_nxt    = pcnt_r;
    exp_len_nxt = exp_len_r;
    n_flush     = '0;
    tail_en     = 1'b0;
    tail_valid  = 1'b0;
    tail_cp     = {13'd0, b};
    tail_cnt    = utf8d_pkg::LEN_1;

    if (pcnt_r != 2'd0 && cont) begin
      if (complete) begin
        tail_en     = 1'b1;
        tail_valid  = 1'b1;
        tail_cp     = decoded_cp;
        tail_cnt    = exp_len_r;
        pcnt_nxt    = '0;
        exp_len_nxt = utf8d_pkg::LEN_BAD;
      end else if (pcnt_r != 2'd3 && !eot) begin
        pend_nxt[pcnt_r] = b;
        pcnt_nxt         = pcnt_r + 2'd1;
      end else begin
        // End of text inside the sequence (or an over-long run): every held
        // byte and this continuation come out as invalid bytes.
        n_flush     = pcnt_r;
        tail_en     = 1'b1;
        pcnt_nxt    = '0;
        exp_len_nxt = utf8d_pkg::LEN_BAD;
      end
    end else begin
      // Nothing held, or the sequence is broken by a fresh byte.
      n_flush = pcnt_r;
      if (len == utf8d_pkg::LEN_1) begin
        tail_en     = 1'b1;
        tail_valid  = 1'b1;
        pcnt_nxt    = '0;
        exp_len_nxt = utf8d_pkg::LEN_BAD;
      end else if (len == utf8d_pkg::LEN_BAD || eot) begin
        tail_en     = 1'b1;
        pcnt_nxt    = '0;
        exp_len_nxt = utf8d_pkg::LEN_BAD;
      end else begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        exp_len_nxt = len;
      end
    end
  end

  assign new_n = {1'b0, n_flush} + {2'b0, tail_en};

  always_comb begin
    for (int i = 0; i < MR; i++) begin
      if (i < utf8d_pkg::PEND_N && 3'(i) < {1'b0, n_flush}) begin
        new_items[i].code_point = {13'd0, pend_r[i % utf8d_pkg::PEND_N]};
        new_items[i].is_valid   = 1'b0;
        new_items[i].byte_count = utf8d_pkg::LEN_1;
      end else begin
        new_items[i].code_point = tail_cp;
        new_items[i].is_valid   = tail_valid;
        new_items[i].byte_count = tail_cnt;
      end
      new_items[i].last_of_run = (3'(i) + 3'd1) == new_n;
    end
  end

  // Queue update: shift out on a pop, then write the new burst just behind
  // whatever remains.
  assign wr_base = qcnt_r - {2'b0, pop};

  always_comb begin
    rel = '0;
    for (int j = 0; j < QD; j++) begin
      q_nxt[j] = q_r[j];
    end
    if (pop) begin
      for (int j = 0; j < QD - 1; j++) begin
        q_nxt[j] = q_r[j+1];
      end
    end
    if (push) begin
      for (int j = 0; j < QD; j++) begin
        rel = 3'(j) - wr_base;
        if (3'(j) >= wr_base && rel < new_n) begin
          q_nxt[j] = new_items[rel[1:0]];
        end
      end
    end
  end

  assign qcnt_nxt = push ? (wr_base + new_n) : wr_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r    <= '0;
      pcnt_r    <= '0;
      exp_len_r <= utf8d_pkg::LEN_BAD;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (push) begin
        pcnt_r    <= pcnt_nxt;
        exp_len_r <= exp_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (push) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- tb/sv/utf8_stream_decoder_core_test.sv -----
// Self-checking testbench for the UTF-8 stream decoder core, with random byte text and stalls.
`timescale 1ns / 1ps

module utf8_stream_decoder_core_test;
  import utf8d_pkg::*;

  // The run is cut off here. The slowest correct run is roughly 300 bytes, each with a drawn gap
  // and up to four results each waiting out a drawn stall; this limit lies well beyond that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 250;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  // One byte request as queued for the driver. A request marked with wait_drain is only
  // presented once every result expected so far has been received.
  typedef struct {
    logic [7:0] data;
    logic       eot;
    logic       wait_drain;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  byte_req_t req_q[$];
  result_t   due_q[$];
  int        due_count = 0;   // size of due_q as left by the previous clock edge
  int        fail_count = 0;
  int        cycle_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        calm_left = 0;
  logic      drain_next = 1'b0;

  // Shadow state of the decoder: the held lead and continuation bytes, how many are held,
  // and the length that the held lead byte announced.
  logic [7:0] held_bytes[3];
  logic [1:0] held_n;
  logic [2:0] held_len;

  // Results caused by the byte currently being predicted.
  result_t run_results[MAX_RESULTS];
  int      run_n;

  utf8_stream_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Length announced by a byte taken as the start of a character.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return LEN_1;
      8'b110?????: return LEN_2;
      8'b1110????: return LEN_3;
      8'b11110???: return LEN_4;
      default:     return LEN_BAD;
    endcase
  endfunction

  function automatic void add_result(input logic [20:0] cp, input logic ok,
                                     input logic [2:0] cnt);
    run_results[run_n].code_point  = cp;
    run_results[run_n].is_valid    = ok;
    run_results[run_n].byte_count  = cnt;
    run_results[run_n].last_of_run = 1'b0;
    run_n++;
  endfunction

  // Every held byte leaves as an invalid single byte, oldest first.
  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) begin
      add_result({13'd0, held_bytes[i]}, 1'b0, LEN_1);
    end
    held_n   = 2'd0;
    held_len = LEN_BAD;
  endfunction

  // Works out the results caused by one accepted byte and queues them in order.
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [20:0] cp;
    logic [2:0]  len;
    logic        fresh;
    fresh = 1'b1;
    run_n = 0;
    if (held_n != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 1'b0;
        if ({1'b0, held_n} + 3'd1 == held_len) begin
          // The continuation byte completes the held character.
          case (held_len)
            LEN_2:   cp = {16'd0, held_bytes[0][4:0]};
            LEN_3:   cp = {17'd0, held_bytes[0][3:0]};
            default: cp = {18'd0, held_bytes[0][2:0]};
          endcase
          for (int i = 1; i < held_n; i++) begin
            cp = (cp << 6) | {15'd0, held_bytes[i][5:0]};
          end
          cp = (cp << 6) | {15'd0, b[5:0]};
          add_result(cp, 1'b1, held_len);
          held_n   = 2'd0;
          held_len = LEN_BAD;
        end else begin
          held_bytes[held_n] = b;
          held_n = held_n + 2'd1;
          // End of text inside a sequence: everything held, this byte too, is invalid.
          if (eot) begin
            flush_held();
          end
        end
      end else begin
        // Broken sequence: the new byte is decoded afresh once the held ones are out.
        flush_held();
      end
    end
    if (fresh) begin
      len = lead_length(b);
      if (len == LEN_1) begin
        add_result({13'd0, b}, 1'b1, LEN_1);
      end else if (len == LEN_BAD || eot) begin
        // A stray byte, or a lead byte with the end mark on it.
        add_result({13'd0, b}, 1'b0, LEN_1);
      end else begin
        held_bytes[0] = b;
        held_n   = 2'd1;
        held_len = len;
      end
    end
    if (run_n > 0) begin
      run_results[run_n - 1].last_of_run = 1'b1;
    end
    for (int i = 0; i < run_n; i++) begin
      due_q.push_back(run_results[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b, input logic eot);
    byte_req_t r;
    r.data       = b;
    r.eot        = eot;
    r.wait_drain = drain_next;
    drain_next   = 1'b0;
    req_q.push_back(r);
  endfunction

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  // Waiting time for one request or result: none during a calm stretch, otherwise often none
  // and else drawn at random.
  function automatic int draw_wait();
    if (calm_left > 0 || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: presents queued byte requests, holding each until it is accepted.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    byte_req_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
      gap_left  = 0;
    end else if (in_tvalid && !in_tready) begin
      // The current request has not been taken yet; keep it on the bus.
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (req_q.size() != 0 &&
                 !(req_q[0].wait_drain && (in_tvalid || due_count != 0))) begin
      head = req_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= head.data;
      in_tlast  <= head.eot;
      // Calm stretches give runs of back-to-back traffic on both sides.
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm_left = 24;
      end
      gap_left = draw_wait();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result sink: stalls out_tready for a drawn number of cycles after each result.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation, then predicts the
  // results of a byte accepted at the same edge. Doing both in this one block keeps the
  // order of queue updates fixed: the check always comes before the prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      held_n    = 2'd0;
      held_len  = LEN_BAD;
      due_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("unexpected result: cp %h valid %b count %0d last %b",
                     out_tdata[20:0], out_tuser, out_tdata[23:21], out_tlast);
          end
        end else begin
          want = due_q.pop_front();
          if (out_tdata[20:0] !== want.code_point || out_tuser !== want.is_valid ||
              out_tdata[23:21] !== want.byte_count || out_tlast !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("wrong result: expected cp %h valid %b count %0d last %b,",
                       want.code_point, want.is_valid, want.byte_count, want.last_of_run);
              $display("              got      cp %h valid %b count %0d last %b",
                       out_tdata[20:0], out_tuser, out_tdata[23:21], out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
      end
      due_count <= due_q.size();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_stream_decoder_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int          random_bytes;
    int          kind;
    int          len;
    int          conts;
    logic [7:0]  b;
    logic        eot;

    // Directed part: field extremes and the special cases of the decoder.
    push_byte(8'h00, 1'b0);                         // smallest ASCII
    push_byte(8'h7F, 1'b0);                         // largest ASCII
    push_byte(8'h80, 1'b0);                         // stray continuation byte
    push_byte(8'hFF, 1'b0);                         // stray byte above every lead pattern
    push_byte(8'hC2, 1'b0);                         // two-byte character
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0);                         // three-byte character
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hF7, 1'b0);                         // four-byte lead giving the top code point
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0);                         // broken after three bytes: four results
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0);                         // end of text inside a sequence
    push_byte(8'h82, 1'b1);
    push_byte(8'hC3, 1'b1);                         // lead byte carrying the end mark
    push_byte(8'hE2, 1'b0);                         // broken by a stray byte
    push_byte(8'hF8, 1'b0);
    push_byte(8'hED, 1'b0);                         // surrogate, passed through as valid
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b1);

    // Random part: mostly well-formed characters with random payload, some broken
    // sequences and some raw noise. The sender waits for the decoder to drain now and then.
    drain_next = 1'b1;
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes > 80 && random_bytes < 86 || random_bytes > 170 && random_bytes < 176) begin
        drain_next = 1'b1;
      end
      kind = $urandom_range(0, 9);
      eot  = ($urandom_range(0, 7) == 0);
      if (kind <= 1) begin
        push_byte({1'b0, 7'($urandom_range(0, 127))}, eot);
        random_bytes += 1;
      end else if (kind <= 7) begin
        len = kind / 2 + 1;
        push_byte(rand_lead(len), 1'b0);
        for (int i = 1; i < len; i++) begin
          push_byte(rand_cont(), (i == len - 1) ? eot : 1'b0);
        end
        random_bytes += len;
      end else if (kind == 8) begin
        // A sequence cut short either by the end mark or by a byte that is no continuation.
        len   = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        push_byte(rand_lead(len), (conts == 0) ? eot : 1'b0);
        for (int i = 1; i <= conts; i++) begin
          push_byte(rand_cont(), (i == conts) ? eot : 1'b0);
        end
        random_bytes += conts + 1;
        if (!eot) begin
          do begin
            b = 8'($urandom_range(0, 255));
          end while (b[7:6] == 2'b10);
          push_byte(b, 1'b0);
          random_bytes += 1;
        end
      end else begin
        push_byte(8'($urandom_range(0, 255)), eot);
        random_bytes += 1;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every expected result to come out, then allow
    // the decoder a few more cycles to show any result it should not produce.
    while (req_q.size() != 0 || in_tvalid || due_count != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (due_q.size() != 0) begin
      fail_count += due_q.size();
      $display("%0d expected results never arrived", due_q.size());
    end
    if (fail_count == 0) begin
      $display("utf8_stream_decoder_core: match");
    end else begin
      $display("utf8_stream_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- utf8_stream_decoder_core.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8_stream_decoder_core.sv
tb/sv/utf8_stream_decoder_core_test.sv
